>>> rtl/u2u_pkg.sv
// Package for the UTF-16 string descriptor to UTF-8 transcoder.
// Holds the job record passed from front to back, queue sizing, the back
// state type and the UTF-8 length and byte helpers. No dependencies.
package u2u_pkg;

    // Longest string in units, header included.
    localparam int MAX_UNITS  = 127;
    localparam int UNITS_W    = 8;
    localparam int BYTES_W    = 10;
    localparam int CP_W       = 21;
    localparam int UNIT_W     = 16;

    // Job queue between front and back. The depth must be a power of two.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTES_W-1:0] CAPACITY_RESET = BYTES_W'(256);

    // Byte count of a UTF-8 sequence, stored as length minus one.
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // One item's worth of output work: up to two code points, then a
    // terminator, or a single failure result.
    typedef struct packed {
        logic              fail;
        logic              a_en;
        logic [1:0]        a_len;
        logic [CP_W-1:0]   a_cp;
        logic              b_en;
        logic [1:0]        b_len;
        logic [UNIT_W-1:0] b_cp;
        logic              term;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_A,
        BK_B,
        BK_TERM,
        BK_FAIL
    } t_bk_state;

    function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [1:0] len;
        if (cp < CP_W'(32'h80)) begin
            len = LEN_1;
        end else if (cp < CP_W'(32'h800)) begin
            len = LEN_2;
        end else if (cp < CP_W'(32'h10000)) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 sequence of cp, which is len long.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0]      len,
                                             input logic [1:0]      idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = cp[7:0];
            LEN_2: begin
                if (idx == 2'd0) begin
                    b = {3'b110, cp[10:6]};
                end else begin
                    b = {2'b10, cp[5:0]};
                end
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

>>> rtl/utf16_string_to_utf8.sv
// Top level of the UTF-16 string descriptor to UTF-8 transcoder.
// Depends on u2u_pkg, u2u_front, u2u_fifo and u2u_back.
//
// The block takes a USB string descriptor as a stream of 16-bit items: a header
// item whose low byte is the declared length, then the UTF-16 content units, the
// final one flagged by last_unit. It returns one UTF-8 byte per result item and
// closes the string with a zero terminator that carries end_of_string. Surrogate
// pairs are joined into one code point, while a lone surrogate is sent as three
// bytes. Bytes are sent only while they fit in output_capacity with one byte kept
// for the terminator; after the first code point that does not fit, data stops
// until the terminator. A header that is also the last unit, or a header while
// output_capacity is zero, gives a single result with status set. Units beyond
// the declared length, or beyond MAX_UNITS - 1 content units, give no bytes.
// Flow: the front part takes a new item in every cycle as long as its job
// queue (four jobs deep) has room, so the input side only stalls when the queue
// is full. The back part sends one byte per cycle through the output register
// while the output is not stalled; an item yields up to seven bytes, terminator
// included. An item passes through the job queue, the back part's job register
// and the output register before its first byte appears. Configuration writes
// are accepted in any cycle; output_capacity must only be changed while the
// block is idle.
module utf16_string_to_utf8 import u2u_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: output_capacity.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    // Input items.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_header,
    input  logic        i_last_unit,
    // Result items.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_status,
    output logic        o_end_of_string
);

    logic accept;
    logic push, pop, empty, full;
    t_job front_job, queue_job;

    // The register port never pushes back.
    assign o_cfg_ready = 1'b1;

    // Stall depends only on the queue fill, never on the valid input.
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_code_unit (i_code_unit),
        .i_header    (i_header),
        .i_last_unit (i_last_unit),
        .o_push      (push),
        .o_job       (front_job)
    );

    // Items that yield nothing never reach the queue.
    u2u_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty),
        .o_full  (full)
    );

    u2u_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (queue_job),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_status        (o_status),
        .o_end_of_string (o_end_of_string)
    );

endmodule

>>> rtl/u2u_front.sv
// Front part of the transcoder: takes units, tracks string state, surrogate
// pairing and the output byte budget, and emits one job per item that yields output.
// Depends on u2u_pkg.
module u2u_front import u2u_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [9:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic [15:0]       i_code_unit,
    input  logic              i_header,
    input  logic              i_last_unit,
    output logic              o_push,
    output t_job              o_job
);

    logic [BYTES_W-1:0] r_capacity;
    logic               r_open,          n_open;
    logic               r_pending_valid, n_pending_valid;
    logic [UNIT_W-1:0]  r_pending_high,  n_pending_high;
    logic [UNITS_W-1:0] r_units_left,    n_units_left;
    logic [BYTES_W-1:0] r_bytes_written, n_bytes_written;
    logic               r_stopped,       n_stopped;

    logic               is_low, is_high, work, pair, flush, hold, c_enc;
    logic               a_want, b_want, a_fit, b_fit, stopped_a;
    logic [UNITS_W-1:0] ul_dec, lim;
    logic [CP_W-1:0]    a_cp;
    logic [1:0]         a_len, b_len;
    logic [BYTES_W:0]   sum_a, sum_b;
    logic [BYTES_W-1:0] bw_a;
    t_job               job;

    always_comb begin
        is_low  = (i_code_unit[15:10] == 6'b110111);
        is_high = (i_code_unit[15:10] == 6'b110110);
        ul_dec  = r_units_left - UNITS_W'(1);
        work    = !i_header && r_open && (r_units_left != '0);
        pair    = work && r_pending_valid && is_low;
        flush   = work && r_pending_valid && !is_low;
        hold    = work && !pair && is_high && (ul_dec != '0) && !i_last_unit;
        c_enc   = work && !pair && !hold;
        a_want  = pair || flush || c_enc;
        b_want  = flush && c_enc;

        if (pair) begin
            a_cp = {1'b0, r_pending_high[9:0], i_code_unit[9:0]} + CP_W'(32'h10000);
        end else if (flush) begin
            a_cp = {5'b0, r_pending_high};
        end else begin
            a_cp = {5'b0, i_code_unit};
        end
        a_len = utf8_len(a_cp);
        b_len = utf8_len({5'b0, i_code_unit});

        // Budget check for the first code point, then for the second with the
        // count that the first one left.
        sum_a     = {1'b0, r_bytes_written} + (BYTES_W+1)'(a_len) + (BYTES_W+1)'(1);
        a_fit     = sum_a < {1'b0, r_capacity};
        stopped_a = r_stopped || (a_want && !a_fit);
        bw_a      = (a_want && !r_stopped && a_fit) ? sum_a[BYTES_W-1:0] : r_bytes_written;
        sum_b     = {1'b0, bw_a} + (BYTES_W+1)'(b_len) + (BYTES_W+1)'(1);
        b_fit     = sum_b < {1'b0, r_capacity};

        job       = '0;
        job.fail  = i_header && ((r_capacity == '0) || i_last_unit);
        job.a_en  = a_want && !r_stopped && a_fit;
        job.a_len = a_len;
        job.a_cp  = a_cp;
        job.b_en  = b_want && !stopped_a && b_fit;
        job.b_len = b_len;
        job.b_cp  = i_code_unit;
        job.term  = !i_header && r_open && i_last_unit;

        lim = {1'b0, i_code_unit[7:1]} - UNITS_W'(1);

        n_open          = r_open;
        n_pending_valid = r_pending_valid;
        n_pending_high  = r_pending_high;
        n_units_left    = r_units_left;
        n_bytes_written = r_bytes_written;
        n_stopped       = r_stopped;

        if (i_header) begin
            n_open          = !job.fail;
            n_pending_valid = 1'b0;
            n_pending_high  = '0;
            n_bytes_written = '0;
            n_stopped       = 1'b0;
            if (job.fail) begin
                n_units_left = '0;
            end else if (i_code_unit[7:0] >= 8'd2) begin
                n_units_left = (lim < UNITS_W'(MAX_UNITS - 1)) ? lim
                                                              : UNITS_W'(MAX_UNITS - 1);
            end else begin
                n_units_left = UNITS_W'(MAX_UNITS - 1);
            end
        end else if (r_open) begin
            if (work) begin
                n_units_left    = ul_dec;
                n_pending_valid = hold;
                n_pending_high  = hold ? i_code_unit : r_pending_high;
            end
            n_stopped = stopped_a || (b_want && !stopped_a && !b_fit);
            n_bytes_written = job.b_en ? sum_b[BYTES_W-1:0] : bw_a;
            if (i_last_unit) begin
                n_open          = 1'b0;
                n_pending_valid = 1'b0;
                n_pending_high  = '0;
                n_units_left    = '0;
                n_bytes_written = '0;
                n_stopped       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CAPACITY_RESET;
            r_open          <= 1'b0;
            r_pending_valid <= 1'b0;
            r_pending_high  <= '0;
            r_units_left    <= '0;
            r_bytes_written <= '0;
            r_stopped       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (i_accept) begin
                r_open          <= n_open;
                r_pending_valid <= n_pending_valid;
                r_pending_high  <= n_pending_high;
                r_units_left    <= n_units_left;
                r_bytes_written <= n_bytes_written;
                r_stopped       <= n_stopped;
            end
        end
    end

    assign o_push = i_accept && (job.fail || job.a_en || job.b_en || job.term);
    assign o_job  = job;

endmodule

>>> rtl/u2u_fifo.sv
// Short job queue between the front and back parts of the transcoder.
// Depends on u2u_pkg for the job record and the depth.
module u2u_fifo import u2u_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/u2u_back.sv
// Back part of the transcoder: walks each job and sends its UTF-8 bytes,
// terminator or failure result one per cycle through an output register
// while the output is not stalled. Depends on u2u_pkg.
module u2u_back import u2u_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_status,
    output logic       o_end_of_string
);

    t_bk_state  r_state, n_state;
    logic [1:0] r_idx,   n_idx;
    t_job       r_job,   n_job;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_status;
    logic       r_out_eos;

    logic       adv, last_step, load;
    t_bk_state  next_ph, start_ph;
    logic [7:0] cur_byte;
    logic       cur_status, cur_eos;

    always_comb begin
        adv = !r_out_valid || !i_out_stall;

        if (i_job.fail) begin
            start_ph = BK_FAIL;
        end else if (i_job.a_en) begin
            start_ph = BK_A;
        end else if (i_job.b_en) begin
            start_ph = BK_B;
        end else begin
            start_ph = BK_TERM;
        end

        cur_byte   = 8'h00;
        cur_status = 1'b0;
        cur_eos    = 1'b0;
        last_step  = 1'b1;
        next_ph    = BK_IDLE;
        case (r_state)
            BK_A: begin
                cur_byte  = utf8_byte(r_job.a_cp, r_job.a_len, r_idx);
                last_step = (r_idx == r_job.a_len);
                if (r_job.b_en) begin
                    next_ph = BK_B;
                end else if (r_job.term) begin
                    next_ph = BK_TERM;
                end
            end
            BK_B: begin
                cur_byte  = utf8_byte({5'b0, r_job.b_cp}, r_job.b_len, r_idx);
                last_step = (r_idx == r_job.b_len);
                if (r_job.term) begin
                    next_ph = BK_TERM;
                end
            end
            BK_TERM: begin
                cur_eos = 1'b1;
            end
            BK_FAIL: begin
                cur_status = 1'b1;
                cur_eos    = 1'b1;
            end
            default: begin
                last_step = 1'b1;
            end
        endcase

        n_state = r_state;
        n_idx   = r_idx;
        n_job   = r_job;
        load    = 1'b0;
        if (r_state == BK_IDLE) begin
            load = !i_empty;
        end else if (adv) begin
            if (!last_step) begin
                n_idx = r_idx + 2'd1;
            end else if (next_ph != BK_IDLE) begin
                n_state = next_ph;
                n_idx   = 2'd0;
            end else begin
                load    = !i_empty;
                n_state = BK_IDLE;
            end
        end
        if (load) begin
            n_state = start_ph;
            n_idx   = 2'd0;
            n_job   = i_job;
        end
        o_pop = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= (r_state != BK_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte   <= cur_byte;
            r_out_status <= cur_status;
            r_out_eos    <= cur_eos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_status        = r_out_status;
    assign o_end_of_string = r_out_eos;

    a_fail_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_eos && (r_out_byte == 8'h00)))
        else $error("failure result with data or without end of string");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> ((r_state == BK_IDLE) || (adv && last_step)))
        else $error("job loaded while the previous one is unfinished");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_B) |-> (r_idx <= r_job.b_len))
        else $error("byte index beyond sequence length");

endmodule
